// ----- rtl/brpd_pkg.sv -----
// ----------------------------------------------------------------------------
// brpd_pkg
// Shared types and constants for the binary partition Rohlin distance block.
// ----------------------------------------------------------------------------
package brpd_pkg;

    localparam int MAX_LENGTH_DEF = 4096;

    // Fixed field widths
    localparam int SUM_W    = 48;
    localparam int ENT_W    = 32;
    localparam int DIST_W   = 34;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    // Log unit: mantissa in Q1.30, thirty fraction bits of log2
    localparam int          LOG_FRAC_W = 30;
    localparam int          LOG_M_W    = 31;
    localparam int          LOG_TOT_W  = 40;
    localparam logic [31:0] LN2_Q32    = 32'hB17217F8;

    // Number of tracked partitions (product, first, second)
    localparam int RUN_N = 3;

    typedef enum logic [1:0] {
        SEL_PROD   = 2'd0,
        SEL_FIRST  = 2'd1,
        SEL_SECOND = 2'd2
    } brpd_sel_t;

    typedef enum logic [3:0] {
        ST_FILL_START,
        ST_FILL_WAIT,
        ST_IDLE,
        ST_CLOSE,
        ST_FLOAD,
        ST_FCLOSE,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } brpd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic fill_start;
        logic fill_write;
        logic accept;
        logic issue;
        logic final_load;
        logic rd_final;
        logic div_start;
        logic ent_store;
        logic out_load;
    } brpd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic log_done;
        logic fill_last;
        logic acc_close;
        logic acc_last;
        logic pend_one;
        logic item_last;
        logic pipe_busy;
        logic div_done;
        logic ent_last;
        logic out_free;
    } brpd_stat_t;

endpackage

// ----- rtl/brpd_log.sv -----
// ----------------------------------------------------------------------------
// brpd_log
// Iterative natural log in Q8.24: log2 by repeated squaring, one squaring
// per cycle, then scaled by ln 2.
// ----------------------------------------------------------------------------
module brpd_log
    import brpd_pkg::*;
#(
    parameter int POS_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] value,
    output logic             done,
    output logic [ENT_W-1:0] result
);

    localparam int K_W   = $clog2(POS_W);
    localparam int SQ_W  = 2 * LOG_M_W;
    localparam int T_W   = SQ_W - LOG_FRAC_W;
    localparam int FP_W  = LOG_FRAC_W + 32;
    localparam int KL_W  = K_W + 32;
    localparam int CNT_W = $clog2(LOG_FRAC_W);

    logic [K_W-1:0]        k_now;
    logic [K_W-1:0]        k_reg;
    logic [LOG_M_W-1:0]    m_init;
    logic [LOG_M_W-1:0]    m_reg;
    logic [LOG_M_W-1:0]    m_next;
    logic [SQ_W-1:0]       sq;
    logic [T_W-1:0]        t_val;
    logic [LOG_FRAC_W-1:0] frac_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  iter_reg;
    logic                  mul_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [FP_W-1:0]       fprod_reg;
    logic [KL_W-1:0]       klog_reg;
    logic [LOG_TOT_W-1:0]  total;
    logic [ENT_W-1:0]      result_reg;

    // Leading one position
    always_comb begin
        k_now = '0;
        for (int i = 0; i < POS_W; i++) begin
            if (value[i]) begin
                k_now = K_W'(i);
            end
        end
    end

    assign m_init = LOG_M_W'(value) << (6'(LOG_FRAC_W) - 6'(k_now));

    // One squaring step; renormalize when the square reaches 2
    assign sq     = SQ_W'(m_reg) * SQ_W'(m_reg);
    assign t_val  = sq[SQ_W-1:LOG_FRAC_W];
    assign m_next = t_val[T_W-1] ? t_val[T_W-1:1] : t_val[T_W-2:0];

    assign total = LOG_TOT_W'(klog_reg) + LOG_TOT_W'(fprod_reg[FP_W-1:LOG_FRAC_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= 1'b0;
            mul_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            mul_reg  <= 1'b0;
            fin_reg  <= mul_reg;
            done_reg <= fin_reg;
            if (start) begin
                iter_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LOG_FRAC_W - 1);
            end else if (iter_reg) begin
                if (cnt_reg == '0) begin
                    iter_reg <= 1'b0;
                    mul_reg  <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            m_reg    <= m_init;
            k_reg    <= k_now;
            frac_reg <= '0;
        end else if (iter_reg) begin
            m_reg    <= m_next;
            frac_reg <= {frac_reg[LOG_FRAC_W-2:0], t_val[T_W-1]};
        end
        if (mul_reg) begin
            fprod_reg <= FP_W'(frac_reg) * FP_W'(LN2_Q32);
            klog_reg  <= KL_W'(k_reg) * KL_W'(LN2_Q32);
        end
        if (fin_reg) begin
            // round to Q8.24
            result_reg <= ENT_W'((total + LOG_TOT_W'(128)) >> 8);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/brpd_div.sv -----
// ----------------------------------------------------------------------------
// brpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brpd_div
    import brpd_pkg::*;
#(
    parameter int DVD_W = SUM_W,
    parameter int DVS_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   part;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign part     = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = part - {1'b0, dvs_reg};
    assign ge       = part >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DVS_W-1:0] : part[DVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/brpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// brpd_ctrl
// Sequencer: log table fill, run closing, end-of-sequence entropy and result.
// ----------------------------------------------------------------------------
module brpd_ctrl
    import brpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  brpd_stat_t stat,
    output brpd_cmd_t  cmd
);

    brpd_state_t state_reg;
    brpd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL_START;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL_START: state_next = ST_FILL_WAIT;
            ST_FILL_WAIT: begin
                if (stat.log_done) begin
                    state_next = stat.fill_last ? ST_IDLE : ST_FILL_START;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.acc_close) begin
                        state_next = ST_CLOSE;
                    end else if (stat.acc_last) begin
                        state_next = ST_FLOAD;
                    end
                end
            end
            ST_CLOSE: begin
                if (stat.pend_one) begin
                    state_next = stat.item_last ? ST_FLOAD : ST_IDLE;
                end
            end
            ST_FLOAD: state_next = ST_FCLOSE;
            ST_FCLOSE: begin
                if (stat.pend_one) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = stat.ent_last ? ST_OUT : ST_DIV_START;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_FILL_START;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_FILL_START: cmd.fill_start = 1'b1;
            ST_FILL_WAIT:  cmd.fill_write = stat.log_done;
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CLOSE:     cmd.issue      = 1'b1;
            ST_FLOAD:     cmd.final_load = 1'b1;
            ST_FCLOSE:    cmd.issue      = 1'b1;
            ST_DRAIN:     cmd.rd_final   = 1'b1;
            ST_DIV_START: cmd.div_start  = 1'b1;
            ST_DIV_WAIT:  cmd.ent_store  = stat.div_done;
            ST_OUT:       cmd.out_load   = stat.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/brpd_dp.sv -----
// ----------------------------------------------------------------------------
// brpd_dp
// Datapath: log table memory, run tracking, close pipeline, entropy and
// output register.
// ----------------------------------------------------------------------------
module brpd_dp
    import brpd_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  brpd_cmd_t           cmd,
    output brpd_stat_t          stat
);

    localparam int POS_W  = $clog2(MAX_LENGTH + 1);
    localparam int PROD_W = POS_W + ENT_W;

    // Log table
    logic [ENT_W-1:0] log_mem [MAX_LENGTH+1];
    logic [POS_W-1:0] fill_cnt_reg;
    logic             log_done;
    logic [ENT_W-1:0] log_result;
    logic [POS_W-1:0] rd_addr;
    logic             rd_en;
    logic [ENT_W-1:0] rdata_reg;

    logic mode_reg;

    // Sequence state
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] close_pos_reg;
    logic [RUN_N-1:0] pend_reg;
    logic             last_reg;
    logic             over_reg;
    logic [ENT_W-1:0] e1_reg;
    logic [ENT_W-1:0] e2_reg;
    logic [POS_W-1:0] start_prod_reg;
    logic [POS_W-1:0] start_first_reg;
    logic [POS_W-1:0] start_second_reg;
    logic [SUM_W-1:0] sum_prod_reg;
    logic [SUM_W-1:0] sum_first_reg;
    logic [SUM_W-1:0] sum_second_reg;

    // Item decode
    logic             bit_a;
    logic             bit_b;
    logic             r1;
    logic             r2;
    logic             pb;
    logic             over;
    logic [RUN_N-1:0] acc_pend;

    // Close pipeline
    brpd_sel_t        issue_sel;
    logic [RUN_N-1:0] issue_mask;
    logic [POS_W-1:0] start_sel;
    logic [POS_W-1:0] mu;
    logic             s1_valid_reg;
    brpd_sel_t        s1_sel_reg;
    logic [POS_W-1:0] s1_mu_reg;
    logic             s2_valid_reg;
    brpd_sel_t        s2_sel_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [SUM_W-1:0] acc_add;

    // Entropy
    brpd_sel_t        ent_sel_reg;
    logic [SUM_W-1:0] dividend;
    logic             div_done;
    logic [SUM_W-1:0] quotient;
    logic [ENT_W-1:0] ent_val;
    logic [ENT_W-1:0] h12_reg;
    logic [ENT_W-1:0] h1_reg;
    logic [ENT_W-1:0] h2_reg;
    logic [ENT_W-1:0] h1_use;
    logic [ENT_W-1:0] h2_use;
    logic [DIST_W-1:0] dist_val;

    // Output stage
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    brpd_log #(
        .POS_W (POS_W)
    ) u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.fill_start),
        .value   (fill_cnt_reg),
        .done    (log_done),
        .result  (log_result)
    );

    brpd_div #(
        .DVD_W (SUM_W),
        .DVS_W (POS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (position_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- log table memory ----------------
    assign rd_en   = cmd.issue | cmd.rd_final;
    assign rd_addr = cmd.issue ? mu : position_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fill_write) begin
            log_mem[fill_cnt_reg] <= log_result;
        end
        if (rd_en) begin
            rdata_reg <= log_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
            mode_reg     <= 1'b0;
        end else begin
            if (cmd.fill_write) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // ---------------- item decode ----------------
    assign bit_a = s_tdata[0];
    assign bit_b = s_tdata[1];
    assign r1    = bit_a & ~bit_b;
    assign r2    = bit_b & ~bit_a;
    assign pb    = mode_reg ? (r1 | r2) : (bit_a | bit_b);
    assign over  = position_reg == POS_W'(MAX_LENGTH);

    always_comb begin
        acc_pend = '0;
        if (!over && position_reg != '0) begin
            acc_pend[SEL_PROD]   = pb;
            acc_pend[SEL_FIRST]  = r1;
            acc_pend[SEL_SECOND] = r2;
        end
    end

    // ---------------- close issue ----------------
    always_comb begin
        if (pend_reg[SEL_PROD]) begin
            issue_sel = SEL_PROD;
        end else if (pend_reg[SEL_FIRST]) begin
            issue_sel = SEL_FIRST;
        end else begin
            issue_sel = SEL_SECOND;
        end
    end

    assign issue_mask = RUN_N'(1) << issue_sel;

    always_comb begin
        case (issue_sel)
            SEL_PROD:   start_sel = start_prod_reg;
            SEL_FIRST:  start_sel = start_first_reg;
            SEL_SECOND: start_sel = start_second_reg;
            default:    start_sel = start_prod_reg;
        endcase
    end

    assign mu      = close_pos_reg - start_sel;
    assign acc_add = SUM_W'(s2_prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg     <= '0;
            close_pos_reg    <= '0;
            pend_reg         <= '0;
            last_reg         <= 1'b0;
            over_reg         <= 1'b0;
            start_prod_reg   <= '0;
            start_first_reg  <= '0;
            start_second_reg <= '0;
            sum_prod_reg     <= '0;
            sum_first_reg    <= '0;
            sum_second_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            ent_sel_reg      <= SEL_PROD;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;

            if (cmd.accept) begin
                pend_reg      <= acc_pend;
                close_pos_reg <= position_reg;
                last_reg      <= s_tlast;
                over_reg      <= over;
                if (!over) begin
                    position_reg <= position_reg + 1'b1;
                end
            end

            // close all three runs at the sequence length
            if (cmd.final_load) begin
                pend_reg      <= '1;
                close_pos_reg <= position_reg;
            end

            if (cmd.issue) begin
                pend_reg <= pend_reg & ~issue_mask;
                case (issue_sel)
                    SEL_PROD:   start_prod_reg   <= close_pos_reg;
                    SEL_FIRST:  start_first_reg  <= close_pos_reg;
                    SEL_SECOND: start_second_reg <= close_pos_reg;
                    default: ;
                endcase
            end

            if (s2_valid_reg) begin
                case (s2_sel_reg)
                    SEL_PROD:   sum_prod_reg   <= sum_prod_reg + acc_add;
                    SEL_FIRST:  sum_first_reg  <= sum_first_reg + acc_add;
                    SEL_SECOND: sum_second_reg <= sum_second_reg + acc_add;
                    default: ;
                endcase
            end

            if (cmd.ent_store) begin
                case (ent_sel_reg)
                    SEL_PROD:  ent_sel_reg <= SEL_FIRST;
                    SEL_FIRST: ent_sel_reg <= SEL_SECOND;
                    default:   ent_sel_reg <= SEL_PROD;
                endcase
            end

            // drop the finished sequence
            if (cmd.out_load) begin
                position_reg     <= '0;
                last_reg         <= 1'b0;
                start_prod_reg   <= '0;
                start_first_reg  <= '0;
                start_second_reg <= '0;
                sum_prod_reg     <= '0;
                sum_first_reg    <= '0;
                sum_second_reg   <= '0;
                ent_sel_reg      <= SEL_PROD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tlast) begin
            e1_reg <= s_tdata[2 +: ENT_W];
            e2_reg <= s_tdata[2 + ENT_W +: ENT_W];
        end
        if (cmd.issue) begin
            s1_sel_reg <= issue_sel;
            s1_mu_reg  <= mu;
        end
        s2_sel_reg  <= s1_sel_reg;
        s2_prod_reg <= PROD_W'(s1_mu_reg) * PROD_W'(rdata_reg);
    end

    // ---------------- entropy ----------------
    always_comb begin
        case (ent_sel_reg)
            SEL_PROD:   dividend = sum_prod_reg;
            SEL_FIRST:  dividend = sum_first_reg;
            SEL_SECOND: dividend = sum_second_reg;
            default:    dividend = sum_prod_reg;
        endcase
    end

    // rdata_reg holds log(N) from the drain phase on; clamp negative results
    assign ent_val = (quotient > SUM_W'(rdata_reg)) ? '0 : rdata_reg - quotient[ENT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.ent_store) begin
            case (ent_sel_reg)
                SEL_PROD:   h12_reg <= ent_val;
                SEL_FIRST:  h1_reg  <= ent_val;
                SEL_SECOND: h2_reg  <= ent_val;
                default: ;
            endcase
        end
    end

    assign h1_use   = mode_reg ? h1_reg : e1_reg;
    assign h2_use   = mode_reg ? h2_reg : e2_reg;
    assign dist_val = {1'b0, h12_reg, 1'b0} - DIST_W'(h1_use) - DIST_W'(h2_use);

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= M_DATA_W'({over_reg, h12_reg, dist_val});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- status ----------------
    assign stat.log_done  = log_done;
    assign stat.fill_last = fill_cnt_reg == POS_W'(MAX_LENGTH);
    assign stat.acc_close = |acc_pend;
    assign stat.acc_last  = s_tlast;
    assign stat.pend_one  = (pend_reg == RUN_N'(1)) || (pend_reg == RUN_N'(2))
                            || (pend_reg == RUN_N'(4));
    assign stat.item_last = last_reg;
    assign stat.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign stat.div_done  = div_done;
    assign stat.ent_last  = !mode_reg || (ent_sel_reg == SEL_SECOND);
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

// ----- rtl/binary_partition_rohlin_distance.sv -----
// Throughput: one position per cycle when no atom closes; each run close (max 2) stalls input.
// Last position: a load step, 3 more run closes, a pipeline drain, then one entropy division
//   (plain mode) or three (reduced), then the load into the output register.
// Reset: aresetn is synchronous, active low; then the log table fills its MAX_LENGTH+1 entries,
//   one log computation per entry, with s_tready low; cfg writes are taken.
// ----------------------------------------------------------------------------
// binary_partition_rohlin_distance
// Rohlin distance between two binary partitions streamed one position per
// item, with optional removal of common boundaries (reduced mode).
// ----------------------------------------------------------------------------
module binary_partition_rohlin_distance
    import brpd_pkg::*;
#(
    // Longest sequence held; longer ones saturate and flag overflow
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Mode register: 1 selects reduced distance
    input  logic                cfg_we,
    input  logic                cfg_wdata,

    // Position items
    input  logic                s_tvalid,
    output logic                s_tready,
    // [0] bit_first, [1] bit_second, [33:2] entropy_first, [65:34] entropy_second
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,     // last position of the sequence

    // Results, one per sequence
    output logic                m_tvalid,
    input  logic                m_tready,
    // [33:0] distance (signed Q9.24), [65:34] product_entropy, [66] overflow
    output logic [M_DATA_W-1:0] m_tdata
);

    brpd_cmd_t  cmd;
    brpd_stat_t stat;

    // The controller sequences the table fill, the closing of atom runs
    // (one run per cycle into a three-stage multiply-accumulate pipe) and
    // the per-sequence entropy divisions. The datapath owns all storage:
    // the log table memory, run starts, length*log(length) sums, the
    // bit-serial divider and the output register, which lets the next
    // sequence start while a result waits for m_tready.
    brpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brpd_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- verif/tb_binary_partition_rohlin_distance.sv -----
// ----------------------------------------------------------------------------
// tb_binary_partition_rohlin_distance
// Self-checking bench for the Rohlin distance block. A directed table
// covers the field extremes, both modes, a mode switch inside a sequence
// and the single-position case. Random sequences with varied boundary
// density follow. Every result is checked against a bit-exact predictor
// that keeps its own run state and log table, or against a row's typed result.
// ----------------------------------------------------------------------------
module tb_binary_partition_rohlin_distance
    import brpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEQ_MAX    = MAX_LENGTH_DEF;
    localparam int unsigned RAND_ITEMS = 1750;
    localparam int unsigned SETTLE     = 24;    // covers run closes plus pipeline drain
    localparam int unsigned DRAIN      = 400;   // longer than three entropy divisions
    localparam int unsigned HOLD_LEN   = 800;   // long receiver back-pressure stretch

    // One result item, laid out as on m_tdata
    typedef struct packed {
        logic        ovf;
        logic [31:0] h;
        logic [33:0] distance;
    } rohlin_t;

    // One row of the directed table
    typedef struct packed {
        bit          set_mode;  // write reduced_mode before this row
        bit          mode;
        bit          a;
        bit          b;
        bit          fin;
        bit [31:0]   e1;
        bit [31:0]   e2;
        bit          known;     // use the typed result instead of the predictor
        rohlin_t     want;
    } stim_row_t;

    localparam rohlin_t ZERO_RES = '0;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    binary_partition_rohlin_distance dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    bit [31:0]   ln_rom [0:SEQ_MAX];
    bit          mode_reduced;
    int unsigned seq_pos;
    int unsigned atom_start [3];    // indexed by brpd_sel_t
    bit [47:0]   atom_sum   [3];

    rohlin_t     pending_dist [$];  // results still to come, oldest first
    stim_row_t   dir_tab [$];

    int          n_errors;
    int unsigned items_sent;
    bit          calm;              // no random idling on either side
    int          hold_req;          // bump to ask the receiver for a long hold-off
    int          hold_seen;
    int unsigned hold_left;

    // ln(v) in Q8.24: log2 by repeated squaring of a Q1.30 mantissa, times ln 2
    function automatic bit [31:0] ln_q24(int unsigned v);
        int unsigned k;
        bit [63:0]   m;
        bit [63:0]   frac;
        bit [63:0]   total;
        k    = 0;
        frac = '0;
        if (v <= 1) return '0;
        while (k < 31 && (v >> (k + 1)) != 0) k++;
        m = (k <= 30) ? (64'(v) << (30 - k)) : (64'(v) >> (k - 30));
        for (int bp = 29; bp >= 0; bp--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac[bp] = 1'b1;
            end
        end
        total = 64'(k) * 64'(LN2_Q32) + ((frac * 64'(LN2_Q32)) >> 30);
        return 32'((total + 64'd128) >> 8);
    endfunction

    // Close the current atom of one partition at position 'at'
    function automatic void close_atom(int unsigned at, brpd_sel_t which);
        int unsigned mu;
        mu = at - atom_start[which];
        if (mu > SEQ_MAX) mu = SEQ_MAX;
        atom_sum[which]   = 48'(64'(atom_sum[which]) + 64'(mu) * 64'(ln_rom[mu]));
        atom_start[which] = at;
    endfunction

    // H = ln(N) - floor(sum / N), clamped at zero
    function automatic bit [31:0] atom_entropy(bit [47:0] acc, int unsigned n);
        bit [63:0] q;
        bit [63:0] l;
        q = 64'(acc) / 64'(n);
        l = 64'(ln_rom[n]);
        return (q > l) ? 32'd0 : 32'(l - q);
    endfunction

    // Advance the sequence by one position; return 1 when a result is due
    function automatic bit partition_step(input bit a, input bit b, input bit fin,
                                          input bit [31:0] e1, input bit [31:0] e2,
                                          output rohlin_t res);
        bit          over;
        bit          r1;
        bit          r2;
        bit          pb;
        int unsigned n;
        bit [31:0]   h12;
        bit [31:0]   h1;
        bit [31:0]   h2;
        res  = '0;
        over = (seq_pos >= SEQ_MAX);
        // Drop positions past the maximum length
        if (!over) begin
            if (seq_pos > 0) begin
                r1 = a & ~b;
                r2 = b & ~a;
                pb = mode_reduced ? (r1 | r2) : (a | b);
                if (pb) close_atom(seq_pos, SEL_PROD);
                if (r1) close_atom(seq_pos, SEL_FIRST);
                if (r2) close_atom(seq_pos, SEL_SECOND);
            end
            seq_pos++;
        end
        if (!fin) return 1'b0;

        n = seq_pos;
        close_atom(n, SEL_PROD);
        close_atom(n, SEL_FIRST);
        close_atom(n, SEL_SECOND);
        h12 = atom_entropy(atom_sum[SEL_PROD], n);
        if (mode_reduced) begin
            h1 = atom_entropy(atom_sum[SEL_FIRST], n);
            h2 = atom_entropy(atom_sum[SEL_SECOND], n);
        end else begin
            h1 = e1;
            h2 = e2;
        end
        res.distance = 34'(2 * 64'(h12) - 64'(h1) - 64'(h2));
        res.h        = h12;
        res.ovf      = over;

        // Start the next sequence from scratch
        seq_pos = 0;
        for (int i = 0; i < 3; i++) begin
            atom_start[i] = 0;
            atom_sum[i]   = '0;
        end
        return 1'b1;
    endfunction

    // Mostly full-range values, with the extremes and realistic entropies mixed in
    function automatic bit [31:0] pick_entropy();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(32'h0900_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_row(bit set_mode, bit mode, bit a, bit b, bit fin,
                                    bit [31:0] e1, bit [31:0] e2, bit known,
                                    rohlin_t want);
        dir_tab.push_back({set_mode, mode, a, b, fin, e1, e2, known, want});
    endfunction

    function automatic void cmp_field(string name, bit [63:0] want, bit [63:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one item, hold it until taken, then predict its result.
    task automatic send_item(bit a, bit b, bit fin, bit [31:0] e1, bit [31:0] e2,
                             bit known, rohlin_t want);
        rohlin_t pred;
        bit      due;
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, e2, e1, b, a};
        s_tlast  <= fin;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
        due = partition_step(a, b, fin, e1, e2, pred);
        if (due) pending_dist.push_back(known ? want : pred);
    endtask

    // Write the mode only once the block has gone quiet.
    task automatic write_mode(bit v);
        s_tvalid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        mode_reduced = v;
    endtask

    // One sequence of 'len' positions with its own boundary density.
    task automatic send_sequence(int unsigned len);
        int unsigned da;
        int unsigned db;
        bit          link;
        bit          a;
        bit          b;
        da   = $urandom_range(100);
        db   = $urandom_range(100);
        link = ($urandom_range(3) == 0);    // correlated bits stress common boundaries
        for (int unsigned i = 0; i < len; i++) begin
            a = ($urandom_range(99) < da);
            if (link) b = ($urandom_range(99) < 85) ? a : ~a;
            else      b = ($urandom_range(99) < db);
            send_item(a, b, i == len - 1, pick_entropy(), pick_entropy(), 1'b0, ZERO_RES);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check each accepted result, then decide next ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rohlin_t got;
        rohlin_t want;
        got = rohlin_t'(m_tdata[$bits(rohlin_t)-1:0]);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dist.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                n_errors++;
            end else begin
                want = pending_dist.pop_front();
                cmp_field("distance", 64'(want.distance), 64'(got.distance));
                cmp_field("product_entropy", 64'(want.h), 64'(got.h));
                cmp_field("overflow", 64'(want.ovf), 64'(got.ovf));
            end
        end
        // Load a long hold-off when the sender asks for one
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned target;
        stim_row_t   r;

        for (int unsigned i = 0; i <= SEQ_MAX; i++) ln_rom[i] = ln_q24(i);
        mode_reduced = 1'b0;
        seq_pos      = 0;
        for (int i = 0; i < 3; i++) begin
            atom_start[i] = 0;
            atom_sum[i]   = '0;
        end

        // Directed rows: set_mode, mode, a, b, last, e1, e2, known, result
        // Single position, zero entropies: H = 0, distance 0
        add_row(0, 0, 1, 1, 1, 32'd0, 32'd0, 1, ZERO_RES);
        // Single position with both entropies at maximum: distance -2*(2^32-1)
        add_row(0, 0, 0, 0, 1, '1, '1, 1, {1'b0, 32'd0, 34'h2_0000_0002});
        // Only the first entropy at maximum
        add_row(0, 0, 1, 0, 1, '1, 32'd0, 1, {1'b0, 32'd0, 34'h3_0000_0001});
        // One atom of length two
        add_row(0, 0, 1, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 0, 0, 1, 32'd0, 32'd0, 1, ZERO_RES);
        // Plain mode with every bit pair but 00
        add_row(0, 0, 1, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 0, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 0, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 1, 1, 32'h0100_0000, 32'h0080_0000, 0, ZERO_RES);
        // Reduced mode: common boundaries drop out, entropy inputs ignored
        add_row(1, 1, 1, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 0, 0, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 0, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 0, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 1, 1, '1, '1, 0, ZERO_RES);
        // Reduced single position: everything zero
        add_row(0, 0, 1, 0, 1, '1, '1, 1, ZERO_RES);
        // Mode switch inside a sequence: reduced first, plain for the rest
        add_row(0, 0, 0, 0, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 0, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(1, 0, 1, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 0, 1, 0, 32'd0, 32'd0, 0, ZERO_RES);
        add_row(0, 0, 1, 0, 1, 32'h0200_0000, 32'h0100_0000, 0, ZERO_RES);

        // Single reset; the log table then fills with s_tready low
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        // Walk the directed table
        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            if (r.set_mode) write_mode(r.mode);
            send_item(r.a, r.b, r.fin, r.e1, r.e2, r.known, r.want);
        end

        // Random sequences in phases, each phase under a fresh mode
        phase  = 0;
        target = items_sent + RAND_ITEMS;
        while (items_sent < target) begin
            write_mode(1'($urandom_range(1)));
            calm = (phase == 2);
            if (phase == 4) begin
                // Stall the receiver while short sequences keep coming
                hold_req++;
                repeat (30) send_sequence($urandom_range(1, 3));
            end else begin
                repeat (8) begin
                    if ($urandom_range(9) == 0) send_sequence($urandom_range(30, 160));
                    else                        send_sequence($urandom_range(1, 24));
                end
            end
            phase++;
        end
        calm = 1'b0;

        // Drain and report
        s_tvalid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (n_errors == 0 && pending_dist.size() == 0) begin
            $display("[binary_partition_rohlin_distance] OK");
        end else begin
            $display("[binary_partition_rohlin_distance] ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, log table fill included
    initial begin
        #3_000_000;
        $display("[binary_partition_rohlin_distance] ERROR");
        $finish;
    end

endmodule
